@@ hw/rtl/dlaq_pkg.sv @@
// Package for the delta-list alarm queue: command and result codes and the
// request record that travels from the front end to the back end. No dependencies.
package dlaq_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [2:0] KIND_ADDED     = 3'd0;
   localparam logic [2:0] KIND_CANCELLED = 3'd1;
   localparam logic [2:0] KIND_FIRED     = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_FULL      = 3'd4;

   // Most alarms one tick may fire.
   localparam int RESULT_CAP = 16;
   localparam int CAP_W      = $clog2(RESULT_CAP);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] time_amount;
      logic [15:0] tag;
      logic [15:0] target_id;
   } req_type;

endpackage

@@ hw/rtl/dlaq_front.sv @@
// Front end of the alarm queue: accepts requests, drops unused commands and
// holds the rest in a two-entry queue for the back end. Uses dlaq_pkg.
module dlaq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   output logic              q_valid,
   input  logic              q_pop,
   output dlaq_pkg::req_type q_item
);

   dlaq_pkg::req_type slot_ff [2];
   dlaq_pkg::req_type push_item;
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   // Decode the incoming request.
   always_comb begin
      push_item.cmd         = req_tuser;
      push_item.time_amount = req_tdata[31:0];
      push_item.tag         = req_tdata[47:32];
      push_item.target_id   = req_tdata[63:48];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && (req_tuser != dlaq_pkg::CMD_NONE);
   assign pop        = q_pop && q_valid;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ff];

   // Queue pointers and fill count.
   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      rd_in    = rd_ff ^ pop;
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/dlaq_back.sv @@
// Back end of the alarm queue: a row of sorted alarm cells with insert, remove
// and tick sequencing, and the result register. Uses dlaq_pkg.
module dlaq_back #(
   parameter int MAX_ALARMS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  dlaq_pkg::req_type q_item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int N = MAX_ALARMS;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FIRE = 1'b1;

   logic [15:0] id_ff  [N], id_in  [N];
   logic [31:0] rem_ff [N], rem_in [N];
   logic [15:0] tag_ff [N], tag_in [N];
   logic [N-1:0] valid_ff, valid_in, exp_ff, exp_in;
   logic [15:0] next_id_ff, next_id_in;
   logic        state_ff, state_in;
   logic [dlaq_pkg::CAP_W-1:0] fired_ff, fired_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_kind_ff, out_kind_in;
   logic [15:0] out_id_ff, out_id_in, out_tag_ff, out_tag_in;
   logic [31:0] out_rem_ff, out_rem_in;
   logic        out_last_ff, out_last_in;
   logic        out_free;
   logic [N-1:0] gt, ins, match, hit_le, first;
   logic        found;
   logic [15:0] c_id, c_tag;
   logic [31:0] c_rem;
   logic [31:0] t;

   assign out_free = !out_valid_ff || rsp_tready;
   assign t        = q_item.time_amount;

   // Compare every cell against the request at once.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         gt[i]    = valid_ff[i] && (rem_ff[i] > t);
         match[i] = valid_ff[i] && (id_ff[i] == q_item.target_id);
      end
      ins[0]    = gt[0] || !valid_ff[0];
      hit_le[0] = match[0];
      first[0]  = match[0];
      for (int i = 1; i < N; i++) begin
         ins[i]    = valid_ff[i-1] && !gt[i-1] && (gt[i] || !valid_ff[i]);
         hit_le[i] = match[i] || hit_le[i-1];
         first[i]  = match[i] && !hit_le[i-1];
      end
      found = hit_le[N-1];
      c_id  = '0;
      c_rem = '0;
      c_tag = '0;
      for (int i = 0; i < N; i++) begin
         if (first[i]) begin
            c_id  = id_ff[i];
            c_rem = rem_ff[i];
            c_tag = tag_ff[i];
         end
      end
   end

   // Sequencer and cell updates.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         id_in[i]  = id_ff[i];
         rem_in[i] = rem_ff[i];
         tag_in[i] = tag_ff[i];
      end
      valid_in     = valid_ff;
      exp_in       = exp_ff;
      next_id_in   = next_id_ff;
      state_in     = state_ff;
      fired_in     = fired_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_rem_in   = out_rem_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_item.cmd)
                  dlaq_pkg::CMD_ADD: begin
                     out_valid_in = 1'b1;
                     out_rem_in   = '0;
                     out_tag_in   = '0;
                     out_last_in  = 1'b1;
                     if (valid_ff[N-1]) begin
                        out_kind_in = dlaq_pkg::KIND_FULL;
                        out_id_in   = '0;
                     end else begin
                        out_kind_in = dlaq_pkg::KIND_ADDED;
                        out_id_in   = next_id_ff;
                        next_id_in  = next_id_ff + 16'd1;
                        for (int i = 1; i < N; i++) begin
                           if (gt[i-1]) begin
                              id_in[i]    = id_ff[i-1];
                              rem_in[i]   = rem_ff[i-1];
                              tag_in[i]   = tag_ff[i-1];
                              valid_in[i] = 1'b1;
                           end
                        end
                        for (int i = 0; i < N; i++) begin
                           if (ins[i]) begin
                              id_in[i]    = next_id_ff;
                              rem_in[i]   = t;
                              tag_in[i]   = q_item.tag;
                              valid_in[i] = 1'b1;
                           end
                        end
                     end
                  end
                  dlaq_pkg::CMD_CANCEL: begin
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b1;
                     if (found) begin
                        out_kind_in = dlaq_pkg::KIND_CANCELLED;
                        out_id_in   = c_id;
                        out_rem_in  = c_rem;
                        out_tag_in  = c_tag;
                        for (int i = 0; i < N - 1; i++) begin
                           if (hit_le[i]) begin
                              id_in[i]    = id_ff[i+1];
                              rem_in[i]   = rem_ff[i+1];
                              tag_in[i]   = tag_ff[i+1];
                              valid_in[i] = valid_ff[i+1];
                           end
                        end
                        valid_in[N-1] = 1'b0;
                     end else begin
                        out_kind_in = dlaq_pkg::KIND_NOT_FOUND;
                        out_id_in   = q_item.target_id;
                        out_rem_in  = '0;
                        out_tag_in  = '0;
                     end
                  end
                  dlaq_pkg::CMD_TICK: begin
                     // Age every cell and mark the expired ones.
                     for (int i = 0; i < N; i++) begin
                        exp_in[i] = valid_ff[i] && !gt[i];
                        rem_in[i] = gt[i] ? rem_ff[i] - t : 32'd0;
                     end
                     fired_in = '0;
                     state_in = ST_FIRE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIRE: begin
            // Fire the head cell and shift the row by one.
            if (!(valid_ff[0] && exp_ff[0])) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = dlaq_pkg::KIND_FIRED;
               out_id_in    = id_ff[0];
               out_rem_in   = '0;
               out_tag_in   = tag_ff[0];
               out_last_in  = !(valid_ff[1] && exp_ff[1])
                  || (fired_ff == dlaq_pkg::CAP_W'(dlaq_pkg::RESULT_CAP - 1));
               fired_in     = fired_ff + 1'b1;
               for (int i = 0; i < N - 1; i++) begin
                  id_in[i]    = id_ff[i+1];
                  rem_in[i]   = rem_ff[i+1];
                  tag_in[i]   = tag_ff[i+1];
                  valid_in[i] = valid_ff[i+1];
                  exp_in[i]   = exp_ff[i+1];
               end
               valid_in[N-1] = 1'b0;
               exp_in[N-1]   = 1'b0;
               if (out_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         exp_ff       <= '0;
         next_id_ff   <= '0;
         state_ff     <= ST_IDLE;
         fired_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         exp_ff       <= exp_in;
         next_id_ff   <= next_id_in;
         state_ff     <= state_in;
         fired_ff     <= fired_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Cell and result payload.
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         id_ff[i]  <= id_in[i];
         rem_ff[i] <= rem_in[i];
         tag_ff[i] <= tag_in[i];
      end
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
      out_rem_ff  <= out_rem_in;
      out_tag_ff  <= out_tag_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_tag_ff, out_rem_ff, out_id_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hw/rtl/delta_list_alarm_queue.sv @@
// Top level of the delta-list alarm queue: joins the front end and back end.
// Depends on dlaq_pkg, dlaq_front and dlaq_back.
//
// Requests arrive on the req_ stream: tuser holds the command (add, cancel,
// tick), tdata the time amount, tag and target id. Results leave on the rsp_
// stream: tuser holds the result kind, tdata the alarm id, remaining ticks
// and tag, and tlast marks the final result of a request.
// An add or cancel is handled when the back end pops it from the request
// queue, and its result is held in the result register that drives rsp_. A
// tick first ages every cell, then fires one alarm per cycle while the
// result register is free (at most RESULT_CAP); a tick that fires nothing
// passes through the fire state and gives no result. Requests with the
// unused command are accepted and dropped. A two-entry queue lets requests
// be accepted while the back end works. If the receiver stalls, the result
// register holds its result and the back end waits; the request queue fills
// and then req_tready falls.
// Reset empties the alarm table, the request queue and the result register
// and sets the next id to zero.
module delta_list_alarm_queue #(
   parameter int MAX_ALARMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // time_amount[31:0], tag[47:32], target_id[63:48]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // issued_id[15:0], remaining[47:16], fired_tag[63:48]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast
);

   dlaq_pkg::req_type q_item;
   logic q_valid, q_pop;

   dlaq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   dlaq_back #(.MAX_ALARMS(MAX_ALARMS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ sim/delta_list_alarm_queue_tb.sv @@
// Self-checking bench for the delta-list alarm queue: drives add, cancel, tick and
// unused-command requests, predicts every result in a local copy of the alarm table and checks them.
// Depends on dlaq_pkg and delta_list_alarm_queue.
`timescale 1ns / 1ps

module delta_list_alarm_queue_tb;

   localparam int SLOTS = 16;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] amount;
      logic [15:0] tag;
      logic [15:0] target;
   } alarm_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] id;
      logic [31:0] remaining;
      logic [15:0] tag;
      logic        last;
   } alarm_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // time_amount[31:0], tag[47:32], target_id[63:48]
   logic [1:0]  req_tuser = dlaq_pkg::CMD_NONE;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;   // issued_id[15:0], remaining[47:16], fired_tag[63:48]
   logic [2:0]  rsp_tuser;   // kind[2:0]
   logic        rsp_tlast;

   delta_list_alarm_queue #(.MAX_ALARMS(SLOTS)) u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted alarm table.
   logic [15:0] tbl_id [SLOTS];
   logic [31:0] tbl_rem [SLOTS];
   logic [15:0] tbl_tag [SLOTS];
   int          tbl_count = 0;
   logic [15:0] tb_next_id = '0;

   alarm_req_type pending_reqs [$];
   alarm_rsp_type expected_rsps [$];
   int          failures = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_cycles = 0;
   bit          hold_go = 1'b0;
   bit          hold_seen = 1'b0;

   // Apply one accepted request to the table and queue its expected results.
   task automatic predict_alarm_queue(input alarm_req_type r);
      int pos;
      int fired;
      alarm_rsp_type e;
      pos = 0;
      fired = 0;
      e = '0;
      case (r.cmd)
         dlaq_pkg::CMD_ADD: begin
            e.last = 1'b1;
            if (tbl_count >= SLOTS) begin
               e.kind = dlaq_pkg::KIND_FULL;
            end else begin
               while (pos < tbl_count && tbl_rem[pos] <= r.amount) pos++;
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_id[i] = tbl_id[i-1];
                  tbl_rem[i] = tbl_rem[i-1];
                  tbl_tag[i] = tbl_tag[i-1];
               end
               tbl_id[pos] = tb_next_id;
               tbl_rem[pos] = r.amount;
               tbl_tag[pos] = r.tag;
               tbl_count++;
               e.kind = dlaq_pkg::KIND_ADDED;
               e.id = tb_next_id;
               tb_next_id++;
            end
            expected_rsps.push_back(e);
         end
         dlaq_pkg::CMD_CANCEL: begin
            e.last = 1'b1;
            while (pos < tbl_count && tbl_id[pos] != r.target) pos++;
            if (pos >= tbl_count) begin
               e.kind = dlaq_pkg::KIND_NOT_FOUND;
               e.id = r.target;
            end else begin
               e.kind = dlaq_pkg::KIND_CANCELLED;
               e.id = tbl_id[pos];
               e.remaining = tbl_rem[pos];
               e.tag = tbl_tag[pos];
               for (int i = pos; i + 1 < tbl_count; i++) begin
                  tbl_id[i] = tbl_id[i+1];
                  tbl_rem[i] = tbl_rem[i+1];
                  tbl_tag[i] = tbl_tag[i+1];
               end
               tbl_count--;
            end
            expected_rsps.push_back(e);
         end
         dlaq_pkg::CMD_TICK: begin
            while (fired < tbl_count && fired < dlaq_pkg::RESULT_CAP
                   && tbl_rem[fired] <= r.amount) begin
               e = '0;
               e.kind = dlaq_pkg::KIND_FIRED;
               e.id = tbl_id[fired];
               e.tag = tbl_tag[fired];
               expected_rsps.push_back(e);
               fired++;
            end
            if (fired > 0) expected_rsps[$].last = 1'b1;
            for (int i = 0; i + fired < tbl_count; i++) begin
               tbl_id[i] = tbl_id[i+fired];
               tbl_tag[i] = tbl_tag[i+fired];
               tbl_rem[i] = (tbl_rem[i+fired] > r.amount)
                            ? tbl_rem[i+fired] - r.amount : '0;
            end
            tbl_count -= fired;
         end
         default: ;
      endcase
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_alarm_queue({req_tuser, req_tdata[31:0], req_tdata[47:32],
                                              req_tdata[63:48]});
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            alarm_req_type r;
            r = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= r.cmd;
            req_tdata <= {r.target, r.tag, r.amount};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold, counted down in cycles.
   always @(posedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_cycles <= 300;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Result monitor and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            alarm_rsp_type got;
            alarm_rsp_type want;
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16], rsp_tdata[63:48], rsp_tlast};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display({"%0t: mismatch expected kind %0d id %h rem %h tag %h last %b,",
                            " actual kind %0d id %h rem %h tag %h last %b"},
                           $time, want.kind, want.id, want.remaining, want.tag, want.last,
                           got.kind, got.id, got.remaining, got.tag, got.last);
                  failures++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic alarm_req_type make_req(input logic [1:0] c, input logic [31:0] a,
                                              input logic [15:0] t, input logic [15:0] id);
      make_req = {c, a, t, id};
   endfunction

   // Random request: mostly adds, cancels of likely live ids, and ticks.
   function automatic alarm_req_type random_req();
      int pick;
      logic [31:0] amt;
      pick = $urandom_range(99);
      amt = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(200);
      if (pick < 45) return make_req(dlaq_pkg::CMD_ADD, amt, 16'($urandom()),
                                     16'($urandom()));
      if (pick < 65) return make_req(dlaq_pkg::CMD_CANCEL, $urandom(), 16'($urandom()),
                                     ($urandom_range(4) == 0) ? 16'($urandom())
                                     : tb_next_id - 16'($urandom_range(1, 20)));
      if (pick < 97) return make_req(dlaq_pkg::CMD_TICK, $urandom_range(60),
                                     16'($urandom()), 16'($urandom()));
      return make_req(dlaq_pkg::CMD_NONE, $urandom(), 16'($urandom()), 16'($urandom()));
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, full table, cancel hits and misses, zero ticks, cap.
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_TICK, 32'd0, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 16'hFFFF,
                                      16'hFFFF));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_ADD, 32'd0, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_TICK, 32'd0, 16'd0, 16'd0));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(make_req(dlaq_pkg::CMD_ADD,
                                         (i % 3 == 0) ? 32'hFFFF_FFFF : 32'd5,
                                         16'(i), 16'd0));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_CANCEL, 32'd0, 16'd0, 16'd2));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF,
                                      16'hFFFF));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_ADD, 32'd5, 16'h1234, 16'd0));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF,
                                      16'hFFFF));
      drain();

      // Random phases with varying idle rates.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 69 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 69 : 0;
         if (ph == 3) begin
            send_idle_pct = 21;
            recv_stall_pct = 21;
         end
         if (ph == 0) hold_go = 1'b1;
         for (int i = 0; i < 100; i++) begin
            pending_reqs.push_back(random_req());
            while (pending_reqs.size() > 4) @(posedge clock);
         end
         drain();
      end

      // Flush the table; wrapping the id counter would need 65536 adds, which would take too long.
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(dlaq_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0));
      drain();

      if (failures == 0)
         $display("delta_list_alarm_queue regression: pass");
      else
         $display("delta_list_alarm_queue regression: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("delta_list_alarm_queue regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/dlaq_pkg.sv
hw/rtl/dlaq_front.sv
hw/rtl/dlaq_back.sv
hw/rtl/delta_list_alarm_queue.sv
sim/delta_list_alarm_queue_tb.sv
